/* hdl/nxc_pkg.sv */
package nxc_pkg;

  localparam int MAX_LEN = 1024;
  localparam int POS_W   = 11;
  localparam int CHAR_W  = 8;

  localparam logic [POS_W-1:0]  POS_MAX    = POS_W'(MAX_LEN);
  localparam logic [CHAR_W-1:0] CH_DOLLAR  = 8'h24;
  localparam logic [CHAR_W-1:0] CH_STAR    = 8'h2A;
  localparam logic [1:0]        HEX_DIGITS = 2'd2;

  typedef enum logic [4:0] {
    PH_START = 5'b00001,
    PH_FIRST = 5'b00010,
    PH_BODY  = 5'b00100,
    PH_HEX   = 5'b01000,
    PH_DONE  = 5'b10000
  } phase_t;

  typedef struct packed {
    logic              valid_res;
    logic              has_checksum;
    logic [POS_W-1:0]  separator_pos;
    logic [CHAR_W-1:0] computed_xor;
  } result_t;

  typedef struct packed {
    logic       ok;
    logic [3:0] val;
  } nibble_t;

  // Decodes one ASCII hex digit of either case.
  function automatic nibble_t hex_nibble(input logic [CHAR_W-1:0] c);
    nibble_t n;
    n.ok  = 1'b1;
    n.val = 4'd0;
    if (c inside {[8'h30:8'h39]}) begin
      n.val = c[3:0];
    end else if (c inside {[8'h41:8'h46], [8'h61:8'h66]}) begin
      n.val = c[3:0] + 4'd9;
    end else begin
      n.ok = 1'b0;
    end
    return n;
  endfunction

endpackage

/* hdl/nxc_ifs.sv */
interface nxc_char_if;
  import nxc_pkg::*;
  logic              valid;
  logic              ready;
  logic [CHAR_W-1:0] char_in;
  logic              last;

  modport source (output valid, output char_in, output last, input ready);
  modport sink   (input valid, input char_in, input last, output ready);
endinterface

interface nxc_res_if;
  import nxc_pkg::*;
  logic              valid;
  logic              ready;
  logic              valid_res;
  logic              has_checksum;
  logic [POS_W-1:0]  separator_pos;
  logic [CHAR_W-1:0] computed_xor;

  modport source (output valid, output valid_res, output has_checksum,
                  output separator_pos, output computed_xor, input ready);
  modport sink   (input valid, input valid_res, input has_checksum,
                  input separator_pos, input computed_xor, output ready);
endinterface

/* hdl/nmea_xor_checksum_check_core.sv */
// A result word enters the result register when the word carrying the
// last character leaves the input register; the sink takes it from there.
// Throughput: one character word per cycle, set by the single registered
// sentence state update; a last character stalls while a result waits.
// Reset: rst_n is synchronous and active low; it empties both registers
// and returns the sentence state to the start of a sentence.
module nmea_xor_checksum_check_core
  import nxc_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  nxc_char_if.sink   in_chan,
  nxc_res_if.source  out_chan
);

  // Input register. It holds one character word until the sentence state
  // takes it in.
  logic              in_v_r;
  logic [CHAR_W-1:0] in_char_r;
  logic              in_last_r;

  // Result register. It holds one finished result word until the sink
  // takes it.
  logic              out_v_r;
  result_t           res_r;

  result_t           res_comb;
  logic              res_free;
  logic              proc;
  logic              in_ready;

  // A character that ends no sentence never needs the result register, so
  // it moves on even while a finished result waits. Only a last character
  // waits for the result register to free up.
  assign res_free = !out_v_r || out_chan.ready;
  assign proc     = in_v_r && (!in_last_r || res_free);
  assign in_ready = !in_v_r || proc;

  assign in_chan.ready = in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else if (in_ready) begin
      in_v_r <= in_chan.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_chan.valid) begin
      in_char_r <= in_chan.char_in;
      in_last_r <= in_chan.last;
    end
  end

  // The sentence state machine works on the registered character and gives
  // the result as it would stand after that character.
  nxc_sentence_fsm u_fsm (
    .clk     (clk),
    .rst_n   (rst_n),
    .step    (proc),
    .char_in (in_char_r),
    .last    (in_last_r),
    .res     (res_comb)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (proc && in_last_r) begin
      out_v_r <= 1'b1;
    end else if (out_chan.ready) begin
      out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (proc && in_last_r) begin
      res_r <= res_comb;
    end
  end

  assign out_chan.valid         = out_v_r;
  assign out_chan.valid_res     = res_r.valid_res;
  assign out_chan.has_checksum  = res_r.has_checksum;
  assign out_chan.separator_pos = res_r.separator_pos;
  assign out_chan.computed_xor  = res_r.computed_xor;

  a_empty_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !in_v_r |-> in_ready)
    else $error("input register empty but not ready");

  a_result_loaded: assert property (@(posedge clk) disable iff (!rst_n)
    proc && in_last_r |=> out_v_r)
    else $error("last character did not produce a result word");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r && !out_chan.ready |-> !(proc && in_last_r))
    else $error("pending result word overwritten");

  a_plain_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r && !res_r.has_checksum |-> res_r.valid_res)
    else $error("sentence without checksum reported invalid");

endmodule

/* hdl/nxc_sentence_fsm.sv */
module nxc_sentence_fsm
  import nxc_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              step,
  input  logic [CHAR_W-1:0] char_in,
  input  logic              last,
  output result_t           res
);

  phase_t            phase_r, phase_nxt;
  logic [CHAR_W-1:0] xor_r, xor_nxt;
  logic [POS_W-1:0]  pos_r, pos_nxt;
  logic [CHAR_W-1:0] hexv_r, hexv_nxt;
  logic [1:0]        seen_r, seen_nxt;
  logic              bad_r, bad_nxt;
  logic [POS_W-1:0]  pos_inc;
  nibble_t           nib;
  logic              has;

  always_comb begin
    phase_nxt = phase_r;
    xor_nxt   = xor_r;
    pos_nxt   = pos_r;
    hexv_nxt  = hexv_r;
    seen_nxt  = seen_r;
    bad_nxt   = bad_r;
    pos_inc   = (pos_r < POS_MAX) ? pos_r + 1'b1 : pos_r;
    nib       = hex_nibble(char_in);
    case (phase_r)
      PH_START: begin
        // The first body character is taken even if it is a star.
        pos_nxt = POS_W'(1);
        if (char_in == CH_DOLLAR) begin
          phase_nxt = PH_FIRST;
        end else begin
          xor_nxt   = char_in;
          phase_nxt = PH_BODY;
        end
      end
      PH_FIRST: begin
        xor_nxt   = char_in;
        pos_nxt   = pos_inc;
        phase_nxt = PH_BODY;
      end
      PH_BODY: begin
        if (char_in == CH_STAR) begin
          phase_nxt = PH_HEX;
          hexv_nxt  = '0;
          seen_nxt  = '0;
          bad_nxt   = 1'b0;
        end else begin
          xor_nxt = xor_r ^ char_in;
          pos_nxt = pos_inc;
        end
      end
      PH_HEX: begin
        if (!nib.ok) begin
          bad_nxt   = 1'b1;
          phase_nxt = PH_DONE;
        end else begin
          hexv_nxt = {hexv_r[3:0], nib.val};
          seen_nxt = seen_r + 1'b1;
          if (seen_r + 1'b1 >= HEX_DIGITS) begin
            phase_nxt = PH_DONE;
          end
        end
      end
      default: begin
      end
    endcase

    has = (phase_nxt == PH_HEX) || (phase_nxt == PH_DONE);
    res.has_checksum  = has;
    res.valid_res     = !has || ((seen_nxt == HEX_DIGITS) && !bad_nxt &&
                                 (hexv_nxt == xor_nxt));
    res.separator_pos = pos_nxt;
    res.computed_xor  = xor_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n || (step && last)) begin
      phase_r <= PH_START;
      xor_r   <= '0;
      pos_r   <= '0;
      hexv_r  <= '0;
      seen_r  <= '0;
      bad_r   <= 1'b0;
    end else if (step) begin
      phase_r <= phase_nxt;
      xor_r   <= xor_nxt;
      pos_r   <= pos_nxt;
      hexv_r  <= hexv_nxt;
      seen_r  <= seen_nxt;
      bad_r   <= bad_nxt;
    end
  end

  a_seen_range: assert property (@(posedge clk) disable iff (!rst_n)
    seen_r <= HEX_DIGITS)
    else $error("hex digit count beyond two");

  a_pos_sat: assert property (@(posedge clk) disable iff (!rst_n)
    pos_r <= POS_MAX)
    else $error("position counter passed its limit");

  a_restart: assert property (@(posedge clk) disable iff (!rst_n)
    step && last |=> phase_r == PH_START && xor_r == '0 && pos_r == '0)
    else $error("state not cleared after the last character");

endmodule
